>>> rtl/abkf_pkg.sv
package abkf_pkg;

  localparam int ANGLE_W   = 32;
  localparam int COV_W     = 40;
  localparam int GAIN_W    = 32;
  localparam int GAIN_FRAC = 24;
  localparam int IN_W      = 25;
  localparam int DT_W      = 16;
  localparam int NOISE_W   = 24;

  // multiplier operands: wide side covers the predicted covariance term
  localparam int OPA_W = 42;
  localparam int OPB_W = 32;
  localparam int RES_W = 48;
  localparam int SUM_W = RES_W + 1;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RESET = 24'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RESET  = 24'd50332;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RESET  = 24'd503316;

  typedef enum logic [3:0] {
    OP_ANG_PRED,
    OP_T1,
    OP_P00_PRED,
    OP_P11_PRED,
    OP_ANG_UPD,
    OP_BIAS_UPD,
    OP_P10_UPD,
    OP_P00_UPD,
    OP_P11_UPD,
    OP_P01_UPD
  } mul_op_t;

  typedef struct packed {
    logic    load_in;
    logic    mul_start;
    mul_op_t mul_op;
    logic    div_start;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[ANGLE_W-1:0];
    end else if (v < lo) begin
      return lo[ANGLE_W-1:0];
    end
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-COV_W+1){1'b0}}, {(COV_W-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[COV_W-1:0];
    end else if (v < lo) begin
      return lo[COV_W-1:0];
    end
    return v[COV_W-1:0];
  endfunction

endpackage

>>> rtl/angle_bias_kalman_filter_unit.sv
// one sample at a time: a new sample is taken only once the last result is in the output register,
// so a stall on the output side also holds off the input
// the time is set by ten products on one shared multiplier (each from a 32x25 and a 32x18 partial product)
// and the 31-step serial divider that forms both gains together
// synchronous reset clears angle, bias and covariance and loads the noise defaults
module angle_bias_kalman_filter_unit import abkf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [NOISE_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [IN_W-1:0]     gyro_rate,
  input  logic signed [IN_W-1:0]     accel_angle,
  input  logic [DT_W-1:0]            time_step,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ANGLE_W-1:0]  filtered_angle,
  output logic signed [ANGLE_W-1:0]  bias_estimate
);

  dp_cmd_t    cmd;
  dp_status_t status;

  abkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  abkf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .gyro_rate      (gyro_rate),
    .accel_angle    (accel_angle),
    .time_step      (time_step),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .filtered_angle (filtered_angle),
    .bias_estimate  (bias_estimate)
  );

endmodule

>>> rtl/abkf_mul.sv
module abkf_mul import abkf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [OPA_W-1:0] a,
  input  logic signed [OPB_W-1:0] b,
  input  logic                    sh24,
  output logic                    done,
  output logic signed [RES_W-1:0] res
);

  localparam int LO_W   = 24;
  localparam int HI_W   = OPA_W - LO_W;
  localparam int PROD_W = OPB_W + LO_W + 1;
  localparam int ACC_W  = OPA_W + OPB_W;
  localparam int SH_HI  = 24;
  localparam int SH_LO  = 16;

  typedef enum logic [1:0] {PH_IDLE, PH_HI, PH_SUM} phase_t;

  phase_t                        phase;
  logic signed [OPB_W-1:0]       b_r;
  logic signed [HI_W-1:0]        a_hi;
  logic                          sh_r;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [LO_W:0]          lo_op;
  logic signed [OPB_W+HI_W-1:0]  hi_prod;
  logic signed [ACC_W-1:0]       rnd;

  assign lo_op   = $signed({1'b0, a[LO_W-1:0]});
  assign hi_prod = (OPB_W+HI_W)'(b_r) * (OPB_W+HI_W)'(a_hi);

  // half an lsb of the result, so the shift rounds to nearest with ties toward plus infinity
  always_comb begin
    rnd = '0;
    if (sh_r) begin
      rnd[SH_HI-1] = 1'b1;
    end else begin
      rnd[SH_LO-1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_HI;
          end
        end
        PH_HI: phase <= PH_SUM;
        PH_SUM: begin
          phase <= PH_IDLE;
          done  <= 1'b1;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (start) begin
          prod <= PROD_W'(b) * PROD_W'(lo_op);
          b_r  <= b;
          a_hi <= a[OPA_W-1:LO_W];
          sh_r <= sh24;
        end
      end
      PH_HI: begin
        acc  <= ACC_W'(prod) + rnd;
        prod <= PROD_W'(hi_prod);
      end
      PH_SUM: acc <= acc + (ACC_W'(prod) <<< LO_W);
      default: ;
    endcase
  end

  assign res = sh_r ? $signed(acc[SH_HI +: RES_W]) : $signed(acc[SH_LO +: RES_W]);

endmodule

>>> rtl/abkf_div.sv
module abkf_div import abkf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [COV_W:0]    den,
  input  logic signed [COV_W-1:0]  num0,
  input  logic signed [COV_W-1:0]  num1,
  output logic                     done,
  output logic signed [GAIN_W-1:0] k0,
  output logic signed [GAIN_W-1:0] k1
);

  localparam int Q_W   = GAIN_W - 1;
  localparam int PRE   = Q_W - GAIN_FRAC;
  localparam int CNT_W = $clog2(Q_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [COV_W-1:0] d;
  logic             zero_den;
  logic [COV_W-1:0] rem [2];
  logic [Q_W-1:0]   qsh [2];
  logic             neg [2];
  logic             ovf [2];

  logic [COV_W-1:0]       mag     [2];
  logic                   num_neg [2];
  logic [COV_W:0]         rem2    [2];
  logic                   ge      [2];
  logic signed [GAIN_W-1:0] gain  [2];

  assign num_neg[0] = num0[COV_W-1];
  assign num_neg[1] = num1[COV_W-1];
  assign mag[0] = num0[COV_W-1] ? (~num0 + 1'b1) : num0;
  assign mag[1] = num1[COV_W-1] ? (~num1 + 1'b1) : num1;

  // one restoring step per cycle on both gains, sharing the divisor
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem2[i] = {rem[i], qsh[i][Q_W-1]};
      ge[i]   = rem2[i] >= {1'b0, d};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d        <= den[COV_W-1:0];
      zero_den <= !(den > 0);
      for (int i = 0; i < 2; i++) begin
        rem[i] <= {{PRE{1'b0}}, mag[i][COV_W-1:PRE]};
        qsh[i] <= {mag[i][PRE-1:0], {GAIN_FRAC{1'b0}}};
        neg[i] <= num_neg[i];
        // quotient reaches 2^31 exactly when |p| >= d * 2^7
        ovf[i] <= {{PRE{1'b0}}, mag[i]} >= {den[COV_W-1:0], {PRE{1'b0}}};
      end
    end else if (busy) begin
      for (int i = 0; i < 2; i++) begin
        rem[i] <= ge[i] ? COV_W'(rem2[i] - {1'b0, d}) : rem2[i][COV_W-1:0];
        qsh[i] <= {qsh[i][Q_W-2:0], ge[i]};
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (zero_den) begin
        gain[i] = '0;
      end else if (ovf[i]) begin
        gain[i] = neg[i] ? {1'b1, {Q_W{1'b0}}} : {1'b0, {Q_W{1'b1}}};
      end else if (neg[i]) begin
        gain[i] = -$signed({1'b0, qsh[i]});
      end else begin
        gain[i] = $signed({1'b0, qsh[i]});
      end
    end
  end

  assign k0 = gain[0];
  assign k1 = gain[1];

endmodule

>>> rtl/abkf_datapath.sv
module abkf_datapath import abkf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  dp_cmd_t                    cmd,
  output dp_status_t                 status,
  input  logic                       cfg_write_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [NOISE_W-1:0]         cfg_data,
  input  logic signed [IN_W-1:0]     gyro_rate,
  input  logic signed [IN_W-1:0]     accel_angle,
  input  logic [DT_W-1:0]            time_step,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [ANGLE_W-1:0]  filtered_angle,
  output logic signed [ANGLE_W-1:0]  bias_estimate
);

  logic [NOISE_W-1:0] angle_noise;
  logic [NOISE_W-1:0] bias_noise;
  logic [NOISE_W-1:0] meas_noise;

  logic signed [IN_W-1:0]    gyro_r;
  logic signed [IN_W-1:0]    accel_r;
  logic [DT_W-1:0]           dt_r;
  logic signed [ANGLE_W-1:0] ang;
  logic signed [ANGLE_W-1:0] bias;
  logic signed [COV_W-1:0]   p00;
  logic signed [COV_W-1:0]   p01;
  logic signed [COV_W-1:0]   p10;
  logic signed [COV_W-1:0]   p11;
  logic signed [OPA_W-1:0]   inner;
  logic signed [ANGLE_W-1:0] y;
  logic signed [GAIN_W-1:0]  k0;
  logic signed [GAIN_W-1:0]  k1;
  mul_op_t                   wb_op;

  logic signed [ANGLE_W:0]   rate;
  logic signed [COV_W:0]     den;
  logic signed [OPA_W-1:0]   mul_a;
  logic signed [OPB_W-1:0]   mul_b;
  logic                      mul_sh24;
  logic                      mul_done;
  logic signed [RES_W-1:0]   res;
  logic signed [COV_W-1:0]   t1;
  logic                      div_done;
  logic signed [GAIN_W-1:0]  div_k0;
  logic signed [GAIN_W-1:0]  div_k1;
  logic signed [OPB_W-1:0]   dt_op;

  assign rate  = (ANGLE_W+1)'(gyro_r) - (ANGLE_W+1)'(bias);
  assign den   = (COV_W+1)'(p00) + $signed((COV_W+1)'(meas_noise));
  assign t1    = res[COV_W-1:0];
  assign dt_op = $signed(OPB_W'(dt_r));

  always_comb begin
    mul_a    = OPA_W'(p00);
    mul_b    = k0;
    mul_sh24 = 1'b1;
    case (cmd.mul_op)
      OP_ANG_PRED: begin
        mul_a    = OPA_W'(rate);
        mul_b    = dt_op;
        mul_sh24 = 1'b0;
      end
      OP_T1: begin
        mul_a    = OPA_W'(p11);
        mul_b    = dt_op;
        mul_sh24 = 1'b0;
      end
      OP_P00_PRED: begin
        mul_a    = inner;
        mul_b    = dt_op;
        mul_sh24 = 1'b0;
      end
      OP_P11_PRED: begin
        mul_a    = $signed(OPA_W'(bias_noise));
        mul_b    = dt_op;
        mul_sh24 = 1'b0;
      end
      OP_ANG_UPD: begin
        mul_a = OPA_W'(y);
        mul_b = k0;
      end
      OP_BIAS_UPD: begin
        mul_a = OPA_W'(y);
        mul_b = k1;
      end
      OP_P10_UPD: begin
        mul_a = OPA_W'(p00);
        mul_b = k1;
      end
      OP_P00_UPD: begin
        mul_a = OPA_W'(p00);
        mul_b = k0;
      end
      OP_P11_UPD: begin
        mul_a = OPA_W'(p01);
        mul_b = k1;
      end
      OP_P01_UPD: begin
        mul_a = OPA_W'(p01);
        mul_b = k0;
      end
      default: ;
    endcase
  end

  abkf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh24  (mul_sh24),
    .done  (mul_done),
    .res   (res)
  );

  abkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .den   (den),
    .num0  (p00),
    .num1  (p10),
    .done  (div_done),
    .k0    (div_k0),
    .k1    (div_k1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_noise <= ANGLE_NOISE_RESET;
      bias_noise  <= BIAS_NOISE_RESET;
      meas_noise  <= MEAS_NOISE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_ANGLE_NOISE: angle_noise <= cfg_data;
        REG_BIAS_NOISE:  bias_noise  <= cfg_data;
        REG_MEAS_NOISE:  meas_noise  <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      ang  <= '0;
      bias <= '0;
      p00  <= '0;
      p01  <= '0;
      p10  <= '0;
      p11  <= '0;
    end else if (mul_done) begin
      case (wb_op)
        OP_ANG_PRED: ang <= sat_angle(SUM_W'(ang) + SUM_W'(res));
        OP_T1: begin
          p01 <= sat_cov(SUM_W'(p01) - SUM_W'(t1));
          p10 <= sat_cov(SUM_W'(p10) - SUM_W'(t1));
        end
        OP_P00_PRED: p00  <= sat_cov(SUM_W'(p00) + SUM_W'(res));
        OP_P11_PRED: p11  <= sat_cov(SUM_W'(p11) + SUM_W'(res));
        OP_ANG_UPD:  ang  <= sat_angle(SUM_W'(ang) + SUM_W'(res));
        OP_BIAS_UPD: bias <= sat_angle(SUM_W'(bias) + SUM_W'(res));
        OP_P10_UPD:  p10  <= sat_cov(SUM_W'(p10) - SUM_W'(res));
        OP_P00_UPD:  p00  <= sat_cov(SUM_W'(p00) - SUM_W'(res));
        OP_P11_UPD:  p11  <= sat_cov(SUM_W'(p11) - SUM_W'(res));
        OP_P01_UPD:  p01  <= sat_cov(SUM_W'(p01) - SUM_W'(res));
        default: ;
      endcase
    end
  end

  // working values of the current sample
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      gyro_r  <= gyro_rate;
      accel_r <= accel_angle;
      dt_r    <= time_step;
    end
    if (cmd.mul_start) begin
      wb_op <= cmd.mul_op;
    end
    // uses p01 and p10 from before the subtraction of t1
    if (mul_done && wb_op == OP_T1) begin
      inner <= OPA_W'(t1) - OPA_W'(p01) - OPA_W'(p10) + $signed(OPA_W'(angle_noise));
    end
    if (cmd.div_start) begin
      y <= sat_angle(SUM_W'(accel_r) - SUM_W'(ang));
    end
    if (div_done) begin
      k0 <= div_k0;
      k1 <= div_k1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_angle <= ang;
      bias_estimate  <= bias;
    end
  end

  assign status.mul_done = mul_done;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

endmodule

>>> rtl/abkf_ctrl.sv
module abkf_ctrl import abkf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_MUL_WAIT,
    S_DIV_ISSUE,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t  state;
  mul_op_t cur_op;

  function automatic mul_op_t next_op(input mul_op_t op);
    case (op)
      OP_ANG_PRED: return OP_T1;
      OP_T1:       return OP_P00_PRED;
      OP_P00_PRED: return OP_P11_PRED;
      OP_ANG_UPD:  return OP_BIAS_UPD;
      OP_BIAS_UPD: return OP_P10_UPD;
      OP_P10_UPD:  return OP_P00_UPD;
      OP_P00_UPD:  return OP_P11_UPD;
      OP_P11_UPD:  return OP_P01_UPD;
      default:     return OP_ANG_PRED;
    endcase
  endfunction

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.mul_start = (state == S_ISSUE);
    cmd.mul_op    = cur_op;
    cmd.div_start = (state == S_DIV_ISSUE);
    cmd.load_out  = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur_op <= OP_ANG_PRED;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op <= OP_ANG_PRED;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (status.mul_done) begin
            if (cur_op == OP_P11_PRED) begin
              state <= S_DIV_ISSUE;
            end else if (cur_op == OP_P01_UPD) begin
              state <= S_OUT;
            end else begin
              cur_op <= next_op(cur_op);
              state  <= S_ISSUE;
            end
          end
        end
        S_DIV_ISSUE: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (status.div_done) begin
            cur_op <= OP_ANG_UPD;
            state  <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_done_waiting: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> state == S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_div_after_predict: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_WAIT |-> cur_op == OP_P11_PRED)
    else $error("gain division started before the prediction finished");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == S_ISSUE && cur_op == OP_ANG_PRED)
    else $error("accepted sample did not start with the angle prediction");
`endif

endmodule

>>> tb/angle_bias_kalman_filter_unit_tb.sv
`timescale 1ns / 1ps

module angle_bias_kalman_filter_unit_tb;
  import abkf_pkg::*;

  localparam int IDLE_PCT       = 16;
  localparam int QUIET_FROM     = 400;
  localparam int QUIET_TO       = 560;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_LEN       = 400;
  localparam int DRAIN_CYCLES   = 90;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_REPORTS    = 10;

  // index 3 is outside the register map and must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [NOISE_W-1:0]   NOISE_MAX  = {NOISE_W{1'b1}};

  localparam logic signed [IN_W-1:0] GYRO_MAX  = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] GYRO_MIN  = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] ACCEL_MAX = 25'sd11796480;
  localparam logic signed [IN_W-1:0] ACCEL_MIN = -25'sd11796480;
  localparam logic [DT_W-1:0]        DT_MAX    = {DT_W{1'b1}};
  localparam int WALK_LIMIT = 11796480 - 32768;

  typedef struct packed {
    logic signed [IN_W-1:0] gyro;
    logic signed [IN_W-1:0] accel;
    logic [DT_W-1:0]        dt;
  } imu_sample_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] bias;
  } axis_estimate_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [NOISE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IN_W-1:0] gyro_rate = '0;
  logic signed [IN_W-1:0] accel_angle = '0;
  logic [DT_W-1:0] time_step = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ANGLE_W-1:0] filtered_angle;
  logic signed [ANGLE_W-1:0] bias_estimate;

  imu_sample_t    pending_samples[$];
  axis_estimate_t expected_estimates[$];

  // filter state mirrored from the block
  longint est_angle;
  longint est_bias;
  longint cov[4];
  logic [NOISE_W-1:0] q_angle;
  logic [NOISE_W-1:0] q_bias;
  logic [NOISE_W-1:0] r_meas;

  int pushed_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int error_count = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int walk_angle = 0;

  angle_bias_kalman_filter_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .gyro_rate(gyro_rate),
    .accel_angle(accel_angle),
    .time_step(time_step),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .filtered_angle(filtered_angle),
    .bias_estimate(bias_estimate)
  );

  initial forever #5 clk = ~clk;

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact product, rounded half up at the shift, magnitude capped at 2^62
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    logic [127:0] prod;
    logic [127:0] half;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    bit neg;
    neg = (a < 0) != (b < 0);
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    prod = {64'd0, mag_a} * {64'd0, mag_b};
    half = 128'd1 << (sh - 1);
    prod = prod + (neg ? half - 128'd1 : half);
    prod = prod >> sh;
    if (prod > 128'h4000_0000_0000_0000) prod = 128'h4000_0000_0000_0000;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint kalman_gain(input longint p, input longint s);
    if (s <= 0) return 0;
    return clamp_bits((p * (longint'(1) <<< GAIN_FRAC)) / s, GAIN_W);
  endfunction

  function automatic axis_estimate_t kalman_step(input logic signed [IN_W-1:0] g,
                                                 input logic signed [IN_W-1:0] a,
                                                 input logic [DT_W-1:0] d);
    longint gyro, accel, dt;
    longint p00, p01, p10, p11;
    longint rate, t1, inner, s, k0, k1, y;
    axis_estimate_t res;
    gyro  = longint'(g);
    accel = longint'(a);
    dt    = longint'(d);
    p00 = cov[0];
    p01 = cov[1];
    p10 = cov[2];
    p11 = cov[3];

    // predict
    rate = gyro - est_bias;
    est_angle = clamp_bits(est_angle + round_mul(dt, rate, 16), ANGLE_W);
    t1 = round_mul(dt, p11, 16);
    inner = t1 - p01 - p10 + longint'(q_angle);
    p00 = clamp_bits(p00 + round_mul(dt, inner, 16), COV_W);
    p01 = clamp_bits(p01 - t1, COV_W);
    p10 = clamp_bits(p10 - t1, COV_W);
    p11 = clamp_bits(p11 + round_mul(longint'(q_bias), dt, 16), COV_W);

    // update
    s  = p00 + longint'(r_meas);
    k0 = kalman_gain(p00, s);
    k1 = kalman_gain(p10, s);
    y  = clamp_bits(accel - est_angle, ANGLE_W);
    est_angle = clamp_bits(est_angle + round_mul(k0, y, GAIN_FRAC), ANGLE_W);
    est_bias  = clamp_bits(est_bias + round_mul(k1, y, GAIN_FRAC), ANGLE_W);
    cov[0] = clamp_bits(p00 - round_mul(k0, p00, GAIN_FRAC), COV_W);
    cov[1] = clamp_bits(p01 - round_mul(k0, p01, GAIN_FRAC), COV_W);
    cov[2] = clamp_bits(p10 - round_mul(k1, p00, GAIN_FRAC), COV_W);
    cov[3] = clamp_bits(p11 - round_mul(k1, p01, GAIN_FRAC), COV_W);

    res.angle = est_angle[ANGLE_W-1:0];
    res.bias  = est_bias[ANGLE_W-1:0];
    return res;
  endfunction

  // mostly a plausible slowly moving axis, with some full-range and odd time steps
  function automatic imu_sample_t random_sample();
    imu_sample_t smp;
    logic [31:0] raw;
    walk_angle = walk_angle + int'($urandom_range(8 * 65536)) - 4 * 65536;
    if (walk_angle > WALK_LIMIT) walk_angle = WALK_LIMIT;
    if (walk_angle < -WALK_LIMIT) walk_angle = -WALK_LIMIT;
    smp.gyro  = IN_W'(int'($urandom_range(40 * 65536)) - 20 * 65536);
    smp.accel = IN_W'(walk_angle + int'($urandom_range(65536)) - 32768);
    smp.dt    = DT_W'($urandom_range(3277, 1));
    case ($urandom_range(9))
      6, 7: begin
        raw = $urandom();
        smp.gyro  = raw[IN_W-1:0];
        smp.accel = IN_W'(int'($urandom_range(2 * 11796480)) - 11796480);
        raw = $urandom();
        smp.dt    = raw[DT_W-1:0];
      end
      8: begin
        smp.dt = '0;
      end
      9: begin
        smp.dt = DT_W'($urandom_range(65535, 32768));
      end
      default: ;
    endcase
    return smp;
  endfunction

  task automatic queue_sample(input logic signed [IN_W-1:0] g,
                              input logic signed [IN_W-1:0] a,
                              input logic [DT_W-1:0] d);
    imu_sample_t smp;
    smp.gyro  = g;
    smp.accel = a;
    smp.dt    = d;
    pending_samples.push_back(smp);
    pushed_count++;
  endtask

  task automatic queue_random(input int count);
    repeat (count) begin
      pending_samples.push_back(random_sample());
      pushed_count++;
    end
  endtask

  task automatic write_noise_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [NOISE_W-1:0] value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE: q_angle = value;
      REG_BIAS_NOISE:  q_bias  = value;
      REG_MEAS_NOISE:  r_meas  = value;
      default: ;
    endcase
  endtask

  // wait until every queued sample has come back, then let the pipeline settle
  task automatic drain_block();
    while (accepted_count != pushed_count || expected_estimates.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic record_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // input side
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_estimates.push_back(kalman_step(gyro_rate, accel_angle, time_step));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 &&
            (($urandom_range(99) >= IDLE_PCT) ||
             (accepted_count >= QUIET_FROM && accepted_count < QUIET_TO))) begin
          imu_sample_t smp;
          smp = pending_samples.pop_front();
          in_valid    <= 1'b1;
          gyro_rate   <= smp.gyro;
          accel_angle <= smp.accel;
          time_step   <= smp.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        axis_estimate_t exp_est;
        if (expected_estimates.size() == 0) begin
          record_error($sformatf("result with nothing expected: angle %0d bias %0d",
                                 filtered_angle, bias_estimate));
        end else begin
          exp_est = expected_estimates.pop_front();
          if (filtered_angle !== exp_est.angle)
            record_error($sformatf("result %0d filtered_angle: expected %0d, got %0d",
                                   results_seen, exp_est.angle, filtered_angle));
          if (bias_estimate !== exp_est.bias)
            record_error($sformatf("result %0d bias_estimate: expected %0d, got %0d",
                                   results_seen, exp_est.bias, bias_estimate));
        end
        results_seen++;
        // long hold-off so the block backs up into its input
        if (results_seen == HOLD_AT) hold_cycles = HOLD_LEN;
      end
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // ends the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    est_angle = 0;
    est_bias  = 0;
    foreach (cov[i]) cov[i] = 0;
    q_angle = ANGLE_NOISE_RESET;
    q_bias  = BIAS_NOISE_RESET;
    r_meas  = MEAS_NOISE_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: field extremes, zero and full time steps
    queue_sample(0, 0, 0);
    queue_sample(0, ACCEL_MAX, 0);
    queue_sample(GYRO_MAX, 0, 0);
    queue_sample(GYRO_MAX, ACCEL_MAX, DT_MAX);
    queue_sample(GYRO_MIN, ACCEL_MIN, DT_MAX);
    queue_sample(GYRO_MAX, ACCEL_MIN, DT_MAX);
    queue_sample(GYRO_MIN, ACCEL_MAX, DT_MAX);
    queue_sample(-1, -1, 1);
    queue_sample(1, 1, 1);
    queue_sample(0, ACCEL_MAX, 16'h8000);
    queue_sample(0, ACCEL_MIN, 16'h8000);
    queue_sample(GYRO_MAX, ACCEL_MAX, 16'h0001);
    queue_sample(GYRO_MIN, ACCEL_MIN, 16'h0001);
    queue_sample(0, 0, DT_MAX);
    repeat (6) queue_sample(25'sd327680, 25'sd655360, 16'd655);
    queue_random(210);
    drain_block();

    // no noise at all: covariance collapses and the innovation variance hits zero
    write_noise_reg(REG_ANGLE_NOISE, '0);
    write_noise_reg(REG_BIAS_NOISE, '0);
    write_noise_reg(REG_MEAS_NOISE, '0);
    write_noise_reg(REG_UNUSED, NOISE_W'($urandom_range(24'hFFFFFF)));
    repeat (4) queue_sample(25'sd65536, 25'sd131072, 0);
    queue_random(116);
    drain_block();

    // gains near zero: the angle integrates the gyro into saturation
    write_noise_reg(REG_MEAS_NOISE, NOISE_MAX);
    repeat (140) queue_sample(GYRO_MAX, ACCEL_MIN, DT_MAX);
    repeat (140) queue_sample(GYRO_MIN, ACCEL_MAX, DT_MAX);
    drain_block();

    write_noise_reg(REG_ANGLE_NOISE, NOISE_MAX);
    write_noise_reg(REG_BIAS_NOISE, NOISE_MAX);
    write_noise_reg(REG_MEAS_NOISE, NOISE_MAX);
    queue_random(150);
    drain_block();

    write_noise_reg(REG_ANGLE_NOISE, NOISE_W'($urandom_range(24'hFFFFFF)));
    write_noise_reg(REG_BIAS_NOISE, NOISE_W'($urandom_range(24'hFFFFFF)));
    write_noise_reg(REG_MEAS_NOISE, NOISE_W'($urandom_range(24'hFFFFFF)));
    queue_random(180);
    drain_block();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> angle_bias_kalman_filter_unit.f
rtl/abkf_pkg.sv
rtl/abkf_mul.sv
rtl/abkf_div.sv
rtl/abkf_datapath.sv
rtl/abkf_ctrl.sv
rtl/angle_bias_kalman_filter_unit.sv
tb/angle_bias_kalman_filter_unit_tb.sv
